[hw/rtl/rgb2hsv_pkg.sv]
// Shared types, constants and helper functions for the RGB to HSV converter.
// No dependencies; every other file of the block imports this package.
package rgb2hsv_pkg;

	localparam int ChanW    = 8;
	localparam int OutW     = 17;
	localparam int DivSteps = 17;   // quotient bits produced by the divider pipe
	localparam int NumW     = 24;   // widest dividend: delta * 65536

	localparam int InDataW  = 24;
	localparam int OutDataW = 56;

	// 60 degrees in Q8 fixed point
	localparam logic [13:0] HueScale = 14'd15360;

	// Sector offsets in Q8 degrees
	localparam logic [OutW-1:0] HueBaseRed   = 17'd0;
	localparam logic [OutW-1:0] HueBaseWrap  = 17'd92160;
	localparam logic [OutW-1:0] HueBaseGreen = 17'd30720;
	localparam logic [OutW-1:0] HueBaseBlue  = 17'd61440;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// First stage: channel extremes and the signed hue difference
	typedef struct packed {
		logic [ChanW-1:0] max_c;
		logic [ChanW-1:0] delta;
		logic [ChanW-1:0] diff_mag;
		logic             diff_neg;
		sector_t          sector;
	} front_t;

	// One restoring-division lane: partial remainder, dividend bits still to
	// shift in (top bit next), quotient bits so far
	typedef struct packed {
		logic [ChanW-1:0]    dvs;
		logic [ChanW-1:0]    rem;
		logic [DivSteps-1:0] num;
		logic [DivSteps-1:0] quo;
	} div_lane_t;

	// Everything that travels through the divider pipe
	typedef struct packed {
		logic [OutW-1:0] value;
		logic [OutW-1:0] hue_base;
		logic            hue_neg;
		div_lane_t       hue;
		div_lane_t       sat;
	} div_t;

	// Load a lane; the quotient fits DivSteps bits, so the top dividend bits
	// already form a remainder below the divisor
	function automatic div_lane_t div_load(logic [NumW-1:0] n, logic [ChanW-1:0] d);
		div_lane_t l;
		l.dvs = d;
		l.rem = ChanW'(n[NumW-1:DivSteps]);
		l.num = n[DivSteps-1:0];
		l.quo = '0;
		return l;
	endfunction

	// One quotient bit of restoring division
	function automatic div_lane_t div_step(div_lane_t l);
		div_lane_t        o;
		logic [ChanW:0]   trial;
		logic             ge;
		trial = {l.rem, l.num[DivSteps-1]};
		ge    = (trial >= {1'b0, l.dvs});
		o.dvs = l.dvs;
		o.rem = ge ? ChanW'(trial - {1'b0, l.dvs}) : trial[ChanW-1:0];
		o.num = {l.num[DivSteps-2:0], 1'b0};
		o.quo = {l.quo[DivSteps-2:0], ge};
		return o;
	endfunction

endpackage

[hw/rtl/rgb2hsv_front.sv]
// Front of the converter: max/min search, sector pick and divider setup.
// Two pipeline stages; depends on rgb2hsv_pkg.
module rgb2hsv_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rgb2hsv_pkg::ChanW-1:0]    red,
	input  logic [rgb2hsv_pkg::ChanW-1:0]    green,
	input  logic [rgb2hsv_pkg::ChanW-1:0]    blue,
	output logic                             out_valid,
	input  logic                             out_ready,
	output rgb2hsv_pkg::div_t                out_data
);
	import rgb2hsv_pkg::*;

	logic   valid_s1, valid_s2;
	logic   ready_s1, ready_s2;
	front_t data_s1, front_d;
	div_t   data_s2, div_d;

	logic [ChanW-1:0] max_c, min_c;
	logic             red_max, green_max;

	// Find extremes; red wins ties, then green
	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		max_c     = red_max ? red : (green_max ? green : blue);
		min_c     = (red <= green) ? ((red <= blue) ? red : blue)
		                           : ((green <= blue) ? green : blue);
		front_d.max_c = max_c;
		front_d.delta = max_c - min_c;
		if (red_max) begin
			front_d.sector   = SECT_RED;
			front_d.diff_neg = (green < blue);
			front_d.diff_mag = (green < blue) ? (blue - green) : (green - blue);
		end else if (green_max) begin
			front_d.sector   = SECT_GREEN;
			front_d.diff_neg = (blue < red);
			front_d.diff_mag = (blue < red) ? (red - blue) : (blue - red);
		end else begin
			front_d.sector   = SECT_BLUE;
			front_d.diff_neg = (red < green);
			front_d.diff_mag = (red < green) ? (green - red) : (red - green);
		end
	end

	// Build dividends, divisors, hue offset and value
	always_comb begin
		logic [NumW-1:0] hue_num;
		logic [NumW-1:0] sat_num;
		hue_num = NumW'(data_s1.diff_mag) * NumW'(HueScale);
		sat_num = {data_s1.delta, 16'h0000};
		div_d.hue = div_load(hue_num, (data_s1.delta == '0) ? ChanW'(1) : data_s1.delta);
		div_d.sat = div_load(sat_num, (data_s1.max_c == '0) ? ChanW'(1) : data_s1.max_c);
		div_d.hue_neg = data_s1.diff_neg;
		unique case (data_s1.sector)
			SECT_RED:   div_d.hue_base = data_s1.diff_neg ? HueBaseWrap : HueBaseRed;
			SECT_GREEN: div_d.hue_base = HueBaseGreen;
			SECT_BLUE:  div_d.hue_base = HueBaseBlue;
			default:    div_d.hue_base = HueBaseRed;
		endcase
		// max * 65536 / 255 = 257 * max, plus one when max is full scale
		div_d.value = OutW'({data_s1.max_c, data_s1.max_c})
		            + OutW'(data_s1.max_c == {ChanW{1'b1}});
	end

	// Advance a stage when it is empty or its successor takes its request
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) data_s1 <= front_d;
		if (ready_s2 && valid_s1) data_s2 <= div_d;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

[hw/rtl/rgb2hsv_div_stage.sv]
// One stage of the divider pipe: one quotient bit for hue and saturation.
// Depends on rgb2hsv_pkg.
module rgb2hsv_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rgb2hsv_pkg::div_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rgb2hsv_pkg::div_t  out_data
);
	import rgb2hsv_pkg::*;

	logic valid_s1;
	div_t data_s1, step_d;

	// Shift one dividend bit into each lane
	always_comb begin
		step_d     = in_data;
		step_d.hue = div_step(in_data.hue);
		step_d.sat = div_step(in_data.sat);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) data_s1 <= step_d;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

[hw/rtl/rgb2hsv_back.sv]
// Back of the converter: applies hue sign and offset, registers the result.
// This register is the output stage; depends on rgb2hsv_pkg.
module rgb2hsv_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rgb2hsv_pkg::div_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rgb2hsv_pkg::OutW-1:0]   hue_q8,
	output logic [rgb2hsv_pkg::OutW-1:0]   saturation_q16,
	output logic [rgb2hsv_pkg::OutW-1:0]   value_q16
);
	import rgb2hsv_pkg::*;

	logic            valid_s1;
	logic [OutW-1:0] hue_s1, sat_s1, val_s1;
	logic [OutW-1:0] hue_d;

	// Negative difference takes the ceiling off the offset; positive adds the floor
	always_comb begin
		if (in_data.hue_neg) begin
			hue_d = in_data.hue_base - in_data.hue.quo
			      - OutW'(in_data.hue.rem != '0);
		end else begin
			hue_d = in_data.hue_base + in_data.hue.quo;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hue_s1 <= hue_d;
			sat_s1 <= in_data.sat.quo;
			val_s1 <= in_data.value;
		end
	end

	assign out_valid      = valid_s1;
	assign hue_q8         = hue_s1;
	assign saturation_q16 = sat_s1;
	assign value_q16      = val_s1;

endmodule

[hw/rtl/rgb_to_hsv_converter.sv]
// RGB to HSV converter, stream in and stream out, one pixel per request.
// Pipeline stages in order: two front stages, 17 divider stages (one quotient bit
// each, restoring division by the 8-bit max or delta) and one output stage.
// Throughput is one pixel per cycle; a stalled output holds every full stage.
// Reset (arst_n low, asynchronous) clears only the stage valid bits.
module rgb_to_hsv_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  logic [rgb2hsv_pkg::InDataW-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// hue_q8 [16:0], saturation_q16 [33:17], value_q16 [50:34], zero [55:51]
	output logic [rgb2hsv_pkg::OutDataW-1:0]    m_tdata
);
	import rgb2hsv_pkg::*;

	logic            pipe_valid [0:DivSteps];
	logic            pipe_ready [0:DivSteps];
	div_t            pipe_data  [0:DivSteps];
	logic [OutW-1:0] hue_q8, saturation_q16, value_q16;

	rgb2hsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.out_valid (pipe_valid[0]),
		.out_ready (pipe_ready[0]),
		.out_data  (pipe_data[0])
	);

	// Chain of divider stages, one quotient bit each
	for (genvar i = 0; i < DivSteps; i++) begin : g_div
		rgb2hsv_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (pipe_valid[i]),
			.in_ready  (pipe_ready[i]),
			.in_data   (pipe_data[i]),
			.out_valid (pipe_valid[i+1]),
			.out_ready (pipe_ready[i+1]),
			.out_data  (pipe_data[i+1])
		);
	end

	rgb2hsv_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (pipe_valid[DivSteps]),
		.in_ready       (pipe_ready[DivSteps]),
		.in_data        (pipe_data[DivSteps]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.hue_q8         (hue_q8),
		.saturation_q16 (saturation_q16),
		.value_q16      (value_q16)
	);

	// Pack the result fields, lowest first
	assign m_tdata = {5'b00000, value_q16, saturation_q16, hue_q8};

endmodule
